// ----- hw/rtl/itp_pkg.sv -----
// shared types and constants for the infix to postfix converter
package itp_pkg;

    localparam int MAX_RESULTS = 32;
    localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);
    localparam int PREC_TBL_W  = 24;
    localparam int PREC_W      = 3;
    localparam int ENTRY_W     = 4;
    localparam int LPAREN_BIT  = 3;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW   = 2'd1;
    localparam logic [1:0] ERR_UNMATCH_RP = 2'd2;
    localparam logic [1:0] ERR_UNMATCH_LP = 2'd3;

    localparam logic [ENTRY_W-1:0] LPAREN_MARK = 4'b1000;

    typedef enum logic [2:0] {
        FUNC_OPERAND  = 3'd0,
        FUNC_OPERATOR = 3'd1,
        FUNC_LPAREN   = 3'd2,
        FUNC_RPAREN   = 3'd3,
        FUNC_END      = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        KIND_OPERAND  = 2'd0,
        KIND_OPERATOR = 2'd1,
        KIND_STATUS   = 2'd2
    } t_out_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [2:0]  func;
        logic [2:0]  op_code;
        logic [1:0]  operand_kind;
        logic [31:0] operand_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [2:0]  out_op;
        logic [1:0]  out_operand_kind;
        logic [31:0] out_operand_value;
        logic        last;
        logic [1:0]  error_code;
    } t_out_item;

    typedef struct packed {
        logic       load;
        logic       pop;
        logic       drop_lp;
        logic       push;
        logic       set_err;
        logic [1:0] err;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  empty;
        logic  top_lp;
        logic  top_lower;
        logic  at_cap;
        logic  out_free;
        logic  pend_valid;
    } t_status;

endpackage

// ----- hw/rtl/itp_ctrl.sv -----
// controller state machine for the infix to postfix converter
module itp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  itp_pkg::t_status i_status,
    output itp_pkg::t_cmd   o_cmd,
    output logic            o_in_stall
);
    import itp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   pop_ok;

    assign pop_ok = !i_status.pend_valid || i_status.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.func == FUNC_OPERATOR || i_status.func == FUNC_LPAREN ||
                        i_status.func == FUNC_RPAREN || i_status.func == FUNC_END) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_READ: begin
                if (i_status.func == FUNC_LPAREN || i_status.empty) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                case (i_status.func)
                    FUNC_OPERATOR: begin
                        if (i_status.top_lp || i_status.top_lower || i_status.at_cap) begin
                            n_state = S_FINISH;
                        end else if (pop_ok) begin
                            n_state = S_READ;
                        end
                    end
                    FUNC_RPAREN: begin
                        if (i_status.top_lp || i_status.at_cap) begin
                            n_state = S_FINISH;
                        end else if (pop_ok) begin
                            n_state = S_READ;
                        end
                    end
                    FUNC_END: begin
                        if (i_status.top_lp) begin
                            n_state = S_READ;
                        end else if (i_status.at_cap) begin
                            n_state = S_FINISH;
                        end else if (pop_ok) begin
                            n_state = S_READ;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = !i_rst_n;
                o_cmd.load = i_in_valid && i_rst_n;
            end
            S_READ: begin
                case (i_status.func)
                    FUNC_LPAREN: begin
                        o_cmd.push = 1'b1;
                    end
                    FUNC_OPERATOR: begin
                        o_cmd.push = i_status.empty;
                    end
                    FUNC_RPAREN: begin
                        o_cmd.set_err = i_status.empty;
                        o_cmd.err     = ERR_UNMATCH_RP;
                    end
                    default: begin
                        o_cmd.push = 1'b0;
                    end
                endcase
            end
            S_EVAL: begin
                case (i_status.func)
                    FUNC_OPERATOR: begin
                        if (i_status.top_lp || i_status.top_lower || i_status.at_cap) begin
                            o_cmd.push = 1'b1;
                        end else begin
                            o_cmd.pop = pop_ok;
                        end
                    end
                    FUNC_RPAREN: begin
                        if (i_status.top_lp) begin
                            o_cmd.drop_lp = 1'b1;
                        end else if (!i_status.at_cap) begin
                            o_cmd.pop = pop_ok;
                        end
                    end
                    FUNC_END: begin
                        if (i_status.top_lp) begin
                            o_cmd.drop_lp = 1'b1;
                            o_cmd.set_err = 1'b1;
                            o_cmd.err     = ERR_UNMATCH_LP;
                        end else if (!i_status.at_cap) begin
                            o_cmd.pop = pop_ok;
                        end
                    end
                    default: begin
                        o_cmd.pop = 1'b0;
                    end
                endcase
            end
            S_FINISH: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ----- hw/rtl/itp_datapath.sv -----
// operator stack, pending token and output register for the converter
module itp_datapath #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  itp_pkg::t_in_item           i_in_item,
    input  itp_pkg::t_cmd               i_cmd,
    output itp_pkg::t_status            o_status,
    input  logic                        i_cfg_wr_en,
    input  logic [itp_pkg::PREC_TBL_W-1:0] i_cfg_wr_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output itp_pkg::t_out_item          o_out_item
);
    import itp_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [ENTRY_W-1:0]    r_mem [STACK_DEPTH];
    logic [ENTRY_W-1:0]    r_top;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         count_m1;
    logic [EMIT_W-1:0]     r_emitted;
    logic [PREC_TBL_W-1:0] r_prec_tbl;
    t_in_item              r_item;
    t_out_item             r_pend;
    logic                  r_pend_valid;
    logic [1:0]            r_err;
    t_out_item             r_out;
    logic                  r_out_valid;
    logic                  full;
    logic                  out_free;
    logic                  emit;
    logic [ENTRY_W-1:0]    push_val;
    logic [PREC_W-1:0]     prec_item;
    logic [PREC_W-1:0]     prec_top;
    t_out_item             pop_tok;
    t_out_item             fin_tok;
    t_out_item             ld_tok;

    function automatic logic [PREC_W-1:0] prec_of(input logic [PREC_TBL_W-1:0] tbl,
                                                  input logic [2:0] code);
        logic [PREC_TBL_W-1:0] sh;
        sh = tbl >> (PREC_W * code);
        return sh[PREC_W-1:0];
    endfunction

    assign count_m1  = r_count - CW'(1);
    assign full      = (r_count == CW'(STACK_DEPTH));
    assign out_free  = !r_out_valid || !i_out_stall;
    assign emit      = i_cmd.pop && r_pend_valid;
    assign prec_item = prec_of(r_prec_tbl, r_item.op_code);
    assign prec_top  = prec_of(r_prec_tbl, r_top[2:0]);
    assign push_val  = (r_item.func == FUNC_LPAREN) ? LPAREN_MARK : {1'b0, r_item.op_code};

    always_comb begin
        pop_tok        = '0;
        pop_tok.out_kind = KIND_OPERATOR;
        pop_tok.out_op = r_top[2:0];
    end

    always_comb begin
        ld_tok                   = '0;
        ld_tok.out_kind          = KIND_OPERAND;
        ld_tok.out_operand_kind  = i_in_item.operand_kind;
        ld_tok.out_operand_value = i_in_item.operand_value;
    end

    always_comb begin
        fin_tok = '0;
        if (r_pend_valid) begin
            fin_tok = r_pend;
        end else begin
            fin_tok.out_kind = KIND_STATUS;
        end
        fin_tok.last       = 1'b1;
        fin_tok.error_code = r_err;
    end

    always_comb begin
        o_status.func       = t_func'(r_item.func);
        o_status.empty      = (r_count == '0);
        o_status.top_lp     = r_top[LPAREN_BIT];
        o_status.top_lower  = (prec_top < prec_item);
        o_status.at_cap     = (r_emitted >= EMIT_W'(MAX_RESULTS));
        o_status.out_free   = out_free;
        o_status.pend_valid = r_pend_valid;
    end

    // stack storage, read port always points at the top entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !full) begin
            r_mem[r_count[AW-1:0]] <= push_val;
        end
        if (r_count != '0) begin
            r_top <= r_mem[count_m1[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_prec_tbl   <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_emitted    <= '0;
            r_err        <= ERR_NONE;
        end else begin
            if (i_cfg_wr_en) begin
                r_prec_tbl <= i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                r_emitted    <= '0;
                r_err        <= ERR_NONE;
                r_pend_valid <= (i_in_item.func == FUNC_OPERAND);
            end
            if (i_cmd.push) begin
                if (full) begin
                    r_err <= ERR_OVERFLOW;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.set_err) begin
                r_err <= i_cmd.err;
            end
            if (i_cmd.drop_lp) begin
                r_count <= count_m1;
            end
            if (i_cmd.pop) begin
                r_count      <= count_m1;
                r_emitted    <= r_emitted + EMIT_W'(1);
                r_pend_valid <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_pend_valid <= 1'b0;
            end
            if (emit || i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
            r_pend <= ld_tok;
        end
        if (i_cmd.pop) begin
            r_pend <= pop_tok;
        end
        if (emit) begin
            r_out <= r_pend;
        end else if (i_cmd.finish) begin
            r_out <= fin_tok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- hw/rtl/infix_to_postfix_converter.sv -----
// top level of the infix to postfix converter
// an operand or unknown item goes from accept straight to finish, a left paren is pushed in read first
// operator, right paren or end: a read and an eval step per stack entry examined, then finish
// one item at a time: the next item is accepted only after the final result is registered,
// and output stalls lengthen this wait
// reset clears the stack count, precedence table and handshake state
// the stack memory itself is not cleared and needs no clearing pass
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  itp_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output itp_pkg::t_out_item          o_out_item,
    input  logic                        i_cfg_wr_en,
    input  logic [itp_pkg::PREC_TBL_W-1:0] i_cfg_wr_data
);
    import itp_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_status ctrl_status;

    // in idle the controller decodes the incoming item directly
    always_comb begin
        ctrl_status = status;
        if (!o_in_stall) begin
            ctrl_status.func = t_func'(i_in_item.func);
        end
    end

    itp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (ctrl_status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    itp_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_item     (i_in_item),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item)
    );

endmodule
